### rtl/pnp_pkg.sv
`default_nettype none
package pnp_pkg;

   localparam int MAX_GRID   = 64;
   localparam int COORD_BITS = 12;
   localparam int GRID_W     = 7;
   localparam int SIZE_W     = 13;
   localparam int CORNER_W   = 7;
   localparam int GRAD_W     = 16;
   localparam int FRAC_W     = 16;
   localparam int HEIGHT_W   = 16;
   localparam int FADE_W     = FRAC_W + 1;

   localparam int NUM_W = COORD_BITS + GRID_W;
   localparam int QUO_W = NUM_W + FRAC_W;
   localparam int REM_W = SIZE_W;

   localparam int CORNER_X_LSB = 0;
   localparam int CORNER_Y_LSB = CORNER_X_LSB + CORNER_W;
   localparam int GRAD_X_LSB   = CORNER_Y_LSB + CORNER_W;
   localparam int GRAD_Y_LSB   = GRAD_X_LSB + GRAD_W;
   localparam int PIX_X_LSB    = GRAD_Y_LSB + GRAD_W;
   localparam int PIX_Y_LSB    = PIX_X_LSB + COORD_BITS;
   localparam int REQ_FIELDS_W = PIX_Y_LSB + COORD_BITS;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = HEIGHT_W + 2 * COORD_BITS;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int CSR_INDEX_W  = 2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_RES     = 2'd2;

   localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RESET  = 13'd256;
   localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RESET = 13'd256;
   localparam logic [GRID_W-1:0] GRID_RES_RESET     = 7'd8;

   typedef struct packed {
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] x;
   } echo_type;

   typedef struct packed {
      logic [CORNER_W-1:0]   corner_y;
      logic [CORNER_W-1:0]   corner_x;
      logic [2*GRAD_W-1:0]   grad;
   } load_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] nq;
   } div_type;

   function automatic div_type div_step(input logic [REM_W-1:0] rem,
                                        input logic [QUO_W-1:0] nq,
                                        input logic [SIZE_W-1:0] size);
      logic [REM_W:0] t;
      div_type r;
      t = {rem, nq[QUO_W-1]};
      if (t >= {1'b0, size}) begin
         r.rem = REM_W'(t - {1'b0, size});
         r.nq  = {nq[QUO_W-2:0], 1'b1};
      end else begin
         r.rem = t[REM_W-1:0];
         r.nq  = {nq[QUO_W-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [FRAC_W-1:0] frac_mul(input logic [FRAC_W-1:0] a,
                                                  input logic [FRAC_W-1:0] b);
      logic [2*FRAC_W-1:0] p;
      p = (2*FRAC_W)'(a) * (2*FRAC_W)'(b);
      return p[2*FRAC_W-1:FRAC_W];
   endfunction

   function automatic logic [FADE_W-1:0] fade_mix(input logic [FRAC_W-1:0] t3,
                                                  input logic [FRAC_W-1:0] t4,
                                                  input logic [FRAC_W-1:0] t5);
      logic signed [21:0] s;
      s = 22'sd6 * $signed({6'd0, t5}) - 22'sd15 * $signed({6'd0, t4})
        + 22'sd10 * $signed({6'd0, t3});
      if (s < 22'sd0) begin
         return '0;
      end else if (s > 22'sd65536) begin
         return FADE_W'(65536);
      end else begin
         return s[FADE_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

### rtl/perlin_noise_pixel_unit.sv
`default_nettype none
// Takes one request per cycle while the output skid register is empty; req_tready is low while it holds a result.
// Depth is set by the 35-stage restoring divider (one quotient bit a stage) for cell and fraction.
// Gradient table: two banks split by column parity, each one write and two reads a cycle.
// Reset clears the pipeline valid bits and the output buffer valid bits and sets the csr registers to
// their reset values; the table is undefined until loaded.
module perlin_noise_pixel_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // corner_x, corner_y, grad_x, grad_y, pix_x, pix_y
   input  logic [pnp_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // height_value, out_x, out_y
   output logic [pnp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pnp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pnp_pkg::SIZE_W-1:0]        csr_data
);
   import pnp_pkg::*;

   localparam int CW    = $clog2(MAX_GRID + 1);
   localparam int HALF  = MAX_GRID / 2 + 1;
   localparam int DEPTH = (MAX_GRID + 1) * HALF;
   localparam int AW    = $clog2(DEPTH);
   localparam int DS    = QUO_W;

   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [GRID_W-1:0] grid_res_ff;
   logic [SIZE_W-1:0] size [2];
   logic              adv;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= IMAGE_WIDTH_RESET;
         height_ff   <= IMAGE_HEIGHT_RESET;
         grid_res_ff <= GRID_RES_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_ff    <= csr_data;
            REG_IMAGE_HEIGHT: height_ff   <= csr_data;
            REG_GRID_RES:     grid_res_ff <= csr_data[GRID_W-1:0];
            default: ;
         endcase
      end
   end

   assign size[0] = (width_ff == '0) ? SIZE_W'(1) : width_ff;
   assign size[1] = (height_ff == '0) ? SIZE_W'(1) : height_ff;

   // divider pipeline
   logic              dv_ff    [0:DS];
   logic              dpix_ff  [0:DS];
   echo_type          decho_ff [0:DS];
   load_type          dload_ff [0:DS];
   logic [QUO_W-1:0]  dnq_ff   [0:DS][2];
   logic [REM_W-1:0]  drem_ff  [0:DS][2];
   div_type           dstep    [0:DS-1][2];
   logic [NUM_W-1:0]  num_in   [2];

   assign req_tready = adv;

   assign num_in[0] = NUM_W'(req_tdata[PIX_X_LSB +: COORD_BITS]) * NUM_W'(grid_res_ff);
   assign num_in[1] = NUM_W'(req_tdata[PIX_Y_LSB +: COORD_BITS]) * NUM_W'(grid_res_ff);

   always_comb begin
      for (int k = 0; k < DS; k++) begin
         for (int i = 0; i < 2; i++) begin
            dstep[k][i] = div_step(drem_ff[k][i], dnq_ff[k][i], size[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DS; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         dv_ff[0] <= req_tvalid;
         for (int k = 0; k < DS; k++) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dpix_ff[0]           <= req_tuser;
         decho_ff[0].x        <= req_tdata[PIX_X_LSB +: COORD_BITS];
         decho_ff[0].y        <= req_tdata[PIX_Y_LSB +: COORD_BITS];
         dload_ff[0].corner_x <= req_tdata[CORNER_X_LSB +: CORNER_W];
         dload_ff[0].corner_y <= req_tdata[CORNER_Y_LSB +: CORNER_W];
         dload_ff[0].grad     <= req_tdata[GRAD_X_LSB +: 2*GRAD_W];
         for (int i = 0; i < 2; i++) begin
            dnq_ff[0][i]  <= {num_in[i], FRAC_W'(0)};
            drem_ff[0][i] <= '0;
         end
         for (int k = 0; k < DS; k++) begin
            dpix_ff[k+1]  <= dpix_ff[k];
            decho_ff[k+1] <= decho_ff[k];
            dload_ff[k+1] <= dload_ff[k];
            for (int i = 0; i < 2; i++) begin
               dnq_ff[k+1][i]  <= dstep[k][i].nq;
               drem_ff[k+1][i] <= dstep[k][i].rem;
            end
         end
      end
   end

   // cell and fraction
   logic              va_ff, pa_ff;
   echo_type          echo_a_ff;
   load_type          load_a_ff;
   logic [CW-1:0]     c0_a_ff [2];
   logic [CW-1:0]     c1_a_ff [2];
   logic [FRAC_W-1:0] f_a_ff  [2];
   logic [NUM_W-1:0]  cell_q  [2];
   logic [CW-1:0]     c0_in   [2];
   logic [CW-1:0]     c1_in   [2];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         cell_q[i] = dnq_ff[DS][i][QUO_W-1:FRAC_W];
         if (cell_q[i] > NUM_W'(MAX_GRID)) begin
            c0_in[i] = CW'(MAX_GRID);
         end else begin
            c0_in[i] = cell_q[i][CW-1:0];
         end
         if (c0_in[i] < CW'(MAX_GRID)) begin
            c1_in[i] = c0_in[i] + CW'(1);
         end else begin
            c1_in[i] = c0_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= dv_ff[DS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff     <= dpix_ff[DS];
         echo_a_ff <= decho_ff[DS];
         load_a_ff <= dload_ff[DS];
         for (int i = 0; i < 2; i++) begin
            c0_a_ff[i] <= c0_in[i];
            c1_a_ff[i] <= c1_in[i];
            f_a_ff[i]  <= dnq_ff[DS][i][FRAC_W-1:0];
         end
      end
   end

   // gradient table, banked by column parity
   logic [2*GRAD_W-1:0] mem_e [DEPTH];
   logic [2*GRAD_W-1:0] mem_o [DEPTH];
   logic [2*GRAD_W-1:0] rde_ff [2];
   logic [2*GRAD_W-1:0] rdo_ff [2];
   logic [CW-1:0]       col_e, col_o;
   logic [AW-1:0]       row0, row1, addr_e0, addr_e1, addr_o0, addr_o1, waddr;
   logic                load_ok, we_e, we_o;

   always_comb begin
      col_e   = c0_a_ff[0][0] ? c1_a_ff[0] : c0_a_ff[0];
      col_o   = c0_a_ff[0][0] ? c0_a_ff[0] : c1_a_ff[0];
      row0    = AW'(AW'(c0_a_ff[1]) * AW'(HALF));
      row1    = AW'(AW'(c1_a_ff[1]) * AW'(HALF));
      addr_e0 = row0 + AW'(col_e >> 1);
      addr_e1 = row1 + AW'(col_e >> 1);
      addr_o0 = row0 + AW'(col_o >> 1);
      addr_o1 = row1 + AW'(col_o >> 1);
      load_ok = (32'(load_a_ff.corner_x) <= MAX_GRID) && (32'(load_a_ff.corner_y) <= MAX_GRID);
      waddr   = AW'(AW'(load_a_ff.corner_y) * AW'(HALF)) + AW'(load_a_ff.corner_x >> 1);
      we_e    = va_ff && (pa_ff == CMD_LOAD) && load_ok && !load_a_ff.corner_x[0];
      we_o    = va_ff && (pa_ff == CMD_LOAD) && load_ok && load_a_ff.corner_x[0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (we_e) begin
            mem_e[waddr] <= load_a_ff.grad;
         end
         rde_ff[0] <= mem_e[addr_e0];
         rde_ff[1] <= mem_e[addr_e1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (we_o) begin
            mem_o[waddr] <= load_a_ff.grad;
         end
         rdo_ff[0] <= mem_o[addr_o0];
         rdo_ff[1] <= mem_o[addr_o1];
      end
   end

   // arithmetic pipeline
   logic vm_ff, vg_ff, vd_ff, ve_ff, vf_ff, vp_ff, vq_ff, vr_ff, vs_ff, vt_ff, vw_ff;
   echo_type echo_m_ff, echo_g_ff, echo_d_ff, echo_e_ff, echo_f_ff;
   echo_type echo_p_ff, echo_q_ff, echo_r_ff, echo_s_ff, echo_t_ff, echo_w_ff;
   logic [1:0]          par_m_ff;
   logic [FRAC_W-1:0]   f_m_ff  [2];
   logic [FRAC_W-1:0]   f_g_ff  [2];
   logic [FRAC_W-1:0]   f_d_ff  [2];
   logic [FRAC_W-1:0]   t2_m_ff [2];
   logic [FRAC_W-1:0]   t3_g_ff [2];
   logic [FRAC_W-1:0]   t3_d_ff [2];
   logic [FRAC_W-1:0]   t4_d_ff [2];
   logic [FRAC_W-1:0]   t3_e_ff [2];
   logic [FRAC_W-1:0]   t4_e_ff [2];
   logic [FRAC_W-1:0]   t5_e_ff [2];
   logic [FADE_W-1:0]   u_f_ff, v_f_ff, v_p_ff, v_q_ff, v_r_ff;
   logic [2*GRAD_W-1:0] gsel [4];
   logic signed [16:0]  dxs [4];
   logic signed [16:0]  dys [4];
   logic signed [32:0]  prx_ff [4];
   logic signed [32:0]  pry_ff [4];
   logic signed [33:0]  dot_ff [4];
   logic signed [34:0]  dif_e_ff [2];
   logic signed [33:0]  a_e_ff   [2];
   logic signed [34:0]  dif_f_ff [2];
   logic signed [33:0]  a_f_ff   [2];
   logic signed [52:0]  prod_p_ff [2];
   logic signed [33:0]  a_p_ff    [2];
   logic signed [34:0]  mix_q_ff  [2];
   logic signed [35:0]  dif_r_ff;
   logic signed [34:0]  m0_r_ff, m0_s_ff;
   logic signed [53:0]  prod_s_ff;
   logic signed [34:0]  n_t_ff;
   logic signed [35:0]  x_w_ff;

   always_comb begin
      gsel[0] = par_m_ff[0] ? rdo_ff[0] : rde_ff[0];
      gsel[1] = par_m_ff[1] ? rdo_ff[0] : rde_ff[0];
      gsel[2] = par_m_ff[0] ? rdo_ff[1] : rde_ff[1];
      gsel[3] = par_m_ff[1] ? rdo_ff[1] : rde_ff[1];
      dxs[0]  = $signed({1'b0, f_m_ff[0]});
      dxs[1]  = $signed({1'b1, f_m_ff[0]});
      dxs[2]  = $signed({1'b0, f_m_ff[0]});
      dxs[3]  = $signed({1'b1, f_m_ff[0]});
      dys[0]  = $signed({1'b0, f_m_ff[1]});
      dys[1]  = $signed({1'b0, f_m_ff[1]});
      dys[2]  = $signed({1'b1, f_m_ff[1]});
      dys[3]  = $signed({1'b1, f_m_ff[1]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
         vg_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vp_ff <= 1'b0;
         vq_ff <= 1'b0;
         vr_ff <= 1'b0;
         vs_ff <= 1'b0;
         vt_ff <= 1'b0;
         vw_ff <= 1'b0;
      end else if (adv) begin
         vm_ff <= va_ff && (pa_ff == CMD_PIXEL);
         vg_ff <= vm_ff;
         vd_ff <= vg_ff;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
         vp_ff <= vf_ff;
         vq_ff <= vp_ff;
         vr_ff <= vq_ff;
         vs_ff <= vr_ff;
         vt_ff <= vs_ff;
         vw_ff <= vt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         echo_m_ff <= echo_a_ff;
         echo_g_ff <= echo_m_ff;
         echo_d_ff <= echo_g_ff;
         echo_e_ff <= echo_d_ff;
         echo_f_ff <= echo_e_ff;
         echo_p_ff <= echo_f_ff;
         echo_q_ff <= echo_p_ff;
         echo_r_ff <= echo_q_ff;
         echo_s_ff <= echo_r_ff;
         echo_t_ff <= echo_s_ff;
         echo_w_ff <= echo_t_ff;
         par_m_ff  <= {c1_a_ff[0][0], c0_a_ff[0][0]};
         for (int i = 0; i < 2; i++) begin
            f_m_ff[i]  <= f_a_ff[i];
            t2_m_ff[i] <= frac_mul(f_a_ff[i], f_a_ff[i]);
            f_g_ff[i]  <= f_m_ff[i];
            t3_g_ff[i] <= frac_mul(t2_m_ff[i], f_m_ff[i]);
            f_d_ff[i]  <= f_g_ff[i];
            t3_d_ff[i] <= t3_g_ff[i];
            t4_d_ff[i] <= frac_mul(t3_g_ff[i], f_g_ff[i]);
            t3_e_ff[i] <= t3_d_ff[i];
            t4_e_ff[i] <= t4_d_ff[i];
            t5_e_ff[i] <= frac_mul(t4_d_ff[i], f_d_ff[i]);
         end
         for (int j = 0; j < 4; j++) begin
            prx_ff[j] <= 33'($signed(gsel[j][GRAD_W-1:0])) * 33'(dxs[j]);
            pry_ff[j] <= 33'($signed(gsel[j][2*GRAD_W-1:GRAD_W])) * 33'(dys[j]);
            dot_ff[j] <= 34'(prx_ff[j]) + 34'(pry_ff[j]);
         end
         dif_e_ff[0] <= 35'(dot_ff[1]) - 35'(dot_ff[0]);
         dif_e_ff[1] <= 35'(dot_ff[3]) - 35'(dot_ff[2]);
         a_e_ff[0]   <= dot_ff[0];
         a_e_ff[1]   <= dot_ff[2];
         u_f_ff      <= fade_mix(t3_e_ff[0], t4_e_ff[0], t5_e_ff[0]);
         v_f_ff      <= fade_mix(t3_e_ff[1], t4_e_ff[1], t5_e_ff[1]);
         for (int i = 0; i < 2; i++) begin
            dif_f_ff[i]  <= dif_e_ff[i];
            a_f_ff[i]    <= a_e_ff[i];
            prod_p_ff[i] <= 53'(dif_f_ff[i]) * 53'($signed({1'b0, u_f_ff}));
            a_p_ff[i]    <= a_f_ff[i];
            mix_q_ff[i]  <= 35'(a_p_ff[i]) + 35'(prod_p_ff[i] >>> FRAC_W);
         end
         v_p_ff    <= v_f_ff;
         v_q_ff    <= v_p_ff;
         v_r_ff    <= v_q_ff;
         dif_r_ff  <= 36'(mix_q_ff[1]) - 36'(mix_q_ff[0]);
         m0_r_ff   <= mix_q_ff[0];
         prod_s_ff <= 54'(dif_r_ff) * 54'($signed({1'b0, v_r_ff}));
         m0_s_ff   <= m0_r_ff;
         n_t_ff    <= m0_s_ff + 35'(prod_s_ff >>> FRAC_W);
         x_w_ff    <= 36'(n_t_ff) + 36'sd1073741824;
      end
   end

   // height mapping and output buffer
   logic signed [52:0]      hy;
   logic [HEIGHT_W-1:0]     height;
   logic [RSP_DATA_W-1:0]   res_data;
   logic [RSP_DATA_W-1:0]   out_d_ff, skid_d_ff;
   logic                    out_v_ff, skid_v_ff, pop;

   always_comb begin
      hy = (53'(x_w_ff) <<< 16) - 53'(x_w_ff);
      if (hy < 53'sd0) begin
         height = '0;
      end else if (hy[52:31] > 22'd65535) begin
         height = '1;
      end else begin
         height = hy[46:31];
      end
      res_data = RSP_DATA_W'({echo_w_ff.y, echo_w_ff.x, height});
   end

   assign adv        = !skid_v_ff;
   assign pop        = out_v_ff && rsp_tready;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            skid_v_ff <= 1'b0;
         end
      end else if (vw_ff) begin
         if (!out_v_ff || pop) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (pop) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (pop) begin
            out_d_ff <= skid_d_ff;
         end
      end else if (vw_ff) begin
         if (!out_v_ff || pop) begin
            out_d_ff <= res_data;
         end else begin
            skid_d_ff <= res_data;
         end
      end
   end

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
   import pnp_pkg::*;

   localparam int SIDE = 65;

   typedef struct {
      logic [HEIGHT_W-1:0]   height;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } pixel_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = CMD_LOAD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = REG_IMAGE_WIDTH;
   logic [SIZE_W-1:0]      csr_data = '0;

   logic [31:0]     grad_store [0:SIDE*SIDE-1];
   logic [SIZE_W-1:0] cfg_width = IMAGE_WIDTH_RESET;
   logic [SIZE_W-1:0] cfg_height = IMAGE_HEIGHT_RESET;
   logic [GRID_W-1:0] cfg_grid = GRID_RES_RESET;
   pixel_result_type pending_pixels [$];
   int              fail_count = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   int              hold_cycles = 0;

   perlin_noise_pixel_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   function automatic void locate(input logic [COORD_BITS-1:0] p,
                                  input logic [SIZE_W-1:0] size,
                                  output int cell_idx, output longint frac);
      longint unsigned s, n, c;
      s = (size == 0) ? 1 : size;
      n = longint'(p) * cfg_grid;
      c = n / s;
      frac = longint'(((n % s) << 16) / s);
      cell_idx = (c > 64) ? 64 : int'(c);
   endfunction

   // only corners whose x and y both lie in 0..16 or 62..64 are loaded
   function automatic bit corner_kept(input int c);
      return (c <= 16) || (c >= 62);
   endfunction

   function automatic bit cell_ok(input int c);
      return (c <= 15) || (c >= 62);
   endfunction

   function automatic longint fade(input longint a);
      longint unsigned ua, t2, t3, t4, t5;
      longint u;
      ua = a;
      t2 = (ua * ua) >> 16;
      t3 = (t2 * ua) >> 16;
      t4 = (t3 * ua) >> 16;
      t5 = (t4 * ua) >> 16;
      u = 6 * longint'(t5) - 15 * longint'(t4) + 10 * longint'(t3);
      if (u < 0) u = 0;
      if (u > 65536) u = 65536;
      return u;
   endfunction

   function automatic longint corner_dot(input int cx, input int cy,
                                         input longint dx, input longint dy);
      logic [31:0] e;
      e = grad_store[cy*SIDE + cx];
      return longint'($signed(e[15:0])) * dx + longint'($signed(e[31:16])) * dy;
   endfunction

   function automatic longint lerp(input longint a, input longint b, input longint u);
      return a + (((b - a) * u) >>> 16);
   endfunction

   function automatic logic [HEIGHT_W-1:0] noise_height(input logic [COORD_BITS-1:0] px,
                                                        input logic [COORD_BITS-1:0] py);
      int cx, cy, cx1, cy1;
      longint fx, fy, u, v, n, h;
      locate(px, cfg_width, cx, fx);
      locate(py, cfg_height, cy, fy);
      cx1 = (cx < 64) ? cx + 1 : 64;
      cy1 = (cy < 64) ? cy + 1 : 64;
      u = fade(fx);
      v = fade(fy);
      n = lerp(lerp(corner_dot(cx, cy, fx, fy), corner_dot(cx1, cy, fx - 65536, fy), u),
               lerp(corner_dot(cx, cy1, fx, fy - 65536),
                    corner_dot(cx1, cy1, fx - 65536, fy - 65536), u), v);
      h = ((n + (longint'(1) << 30)) * 65535) >>> 31;
      if (h < 0) h = 0;
      if (h > 65535) h = 65535;
      return h[15:0];
   endfunction

   task automatic send_request(input logic cmd, input logic [6:0] cx, input logic [6:0] cy,
                               input logic [15:0] gx, input logic [15:0] gy,
                               input logic [11:0] px, input logic [11:0] py);
      pixel_result_type r;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b0, py, px, gy, gx, cy, cx};
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_LOAD) begin
         if (cx <= 64 && cy <= 64) grad_store[cy*SIDE + cx] = {gy, gx};
      end else begin
         r.height = noise_height(px, py);
         r.x = px;
         r.y = py;
         pending_pixels = {pending_pixels, r};
      end
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
      send_request(CMD_PIXEL, 7'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
                   px, py);
   endtask

   task automatic send_load(input logic [6:0] cx, input logic [6:0] cy,
                            input logic [15:0] gx, input logic [15:0] gy);
      send_request(CMD_LOAD, cx, cy, gx, gy, 12'($urandom), 12'($urandom));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [SIZE_W-1:0] val);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_IMAGE_WIDTH: cfg_width = val;
         REG_IMAGE_HEIGHT: cfg_height = val;
         REG_GRID_RES: cfg_grid = val[GRID_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                               input logic [GRID_W-1:0] g);
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      write_reg(REG_GRID_RES, g);
   endtask

   function automatic logic [11:0] pick_coord(input logic [SIZE_W-1:0] size);
      int top, c;
      longint f;
      logic [11:0] p;
      top = (size == 0) ? 0 : size - 1;
      if (top > 4095) top = 4095;
      do begin
         if ($urandom_range(9) == 0) p = 12'($urandom);
         else p = 12'($urandom_range(0, top));
         locate(p, size, c, f);
      end while (!cell_ok(c));
      return p;
   endfunction

   task automatic test_fill_table();
      logic [15:0] gx, gy;
      for (int cy = 0; cy < SIDE; cy++) begin
         for (int cx = 0; cx < SIDE; cx++) begin
            if (corner_kept(cx) && corner_kept(cy)) begin
               case ($urandom_range(3))
                  0: begin gx = 16'sd16384; gy = -16'sd16384; end
                  1: begin gx = -16'sd16384; gy = 16'sd16384; end
                  default: begin gx = 16'($urandom); gy = 16'($urandom); end
               endcase
               send_load(7'(cx), 7'(cy), gx, gy);
            end
         end
      end
   endtask

   task automatic test_directed();
      send_load(7'd65, 7'd0, 16'h7fff, 16'h8000);
      send_load(7'd0, 7'd127, 16'h8000, 16'h7fff);
      send_load(7'd0, 7'd0, 16'h7fff, 16'h7fff);
      send_load(7'd1, 7'd0, 16'h8000, 16'h8000);
      send_load(7'd64, 7'd64, 16'hffff, 16'h0000);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd16, 12'd16);
      send_pixel(12'd31, 12'd5);
      send_pixel(12'd255, 12'd255);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      set_geometry(13'd0, 13'd0, 7'd0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd2048);
      set_geometry(13'd1, 13'd1, 7'd64);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1, 12'd4095);
      set_geometry(13'd4096, 13'd8191, 7'd127);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd2048, 12'd1);
      set_geometry(13'd3, 13'd7, 7'd8);
      send_pixel(12'd1, 12'd2);
      send_pixel(12'd2, 12'd6);
   endtask

   task automatic test_random(input int count, input int idle, input int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (count) begin
         if ($urandom_range(4) == 0)
            send_load(7'($urandom_range(9) == 0 ? $urandom : $urandom_range(0, 64)),
                      7'($urandom_range(9) == 0 ? $urandom : $urandom_range(0, 64)),
                      16'($urandom), 16'($urandom));
         else
            send_pixel(pick_coord(cfg_width), pick_coord(cfg_height));
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      repeat (200) send_pixel(pick_coord(cfg_width), pick_coord(cfg_height));
   endtask

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      pixel_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected result %h", rsp_tdata);
            fail_count++;
         end else begin
            e = pending_pixels.pop_front();
            if (rsp_tdata[15:0] !== e.height) begin
               $error("height_value expected %0d actual %0d", e.height, rsp_tdata[15:0]);
               fail_count++;
            end
            if (rsp_tdata[27:16] !== e.x) begin
               $error("out_x expected %0d actual %0d", e.x, rsp_tdata[27:16]);
               fail_count++;
            end
            if (rsp_tdata[39:28] !== e.y) begin
               $error("out_y expected %0d actual %0d", e.y, rsp_tdata[39:28]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #(12 * 2_000_000);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_table();
      test_directed();
      set_geometry(13'd256, 13'd256, 7'd8);
      test_random(320, 0, 0);
      set_geometry(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                   7'($urandom_range(1, 64)));
      test_random(320, 61, 0);
      set_geometry(13'($urandom_range(1, 300)), 13'($urandom_range(1, 300)),
                   7'($urandom_range(1, 64)));
      test_random(320, 0, 61);
      set_geometry(13'($urandom_range(1, 8191)), 13'($urandom_range(1, 8191)),
                   7'($urandom));
      test_random(320, 35, 35);
      set_geometry(13'd512, 13'd128, 7'd16);
      test_backpressure();
      wait_drained();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

### perlin_noise_pixel_unit.f
rtl/pnp_pkg.sv
rtl/perlin_noise_pixel_unit.sv
tb/tb.sv
